// ===== sv/ebml_vint_decoder_core_defines.svh =====
// Assertion macros shared by the EBML variable-size integer decoder RTL.
`ifndef EBML_VINT_DECODER_CORE_DEFINES_SVH
`define EBML_VINT_DECODER_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define EVD_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("ebml vint decoder: check failed");

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define EVD_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("ebml vint decoder: check failed");

`endif

// ===== sv/ebmlvd_pkg.sv =====
// Package: widths, register map and bias table of the EBML vint decoder.
package ebmlvd_pkg;

	localparam int BYTE_W  = 8;
	localparam int ACC_W   = 56;
	localparam int VALUE_W = 57;
	localparam int LEN_W   = 4;
	localparam int CNT_W   = 3;
	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;

	typedef logic [BYTE_W-1:0]  byte_t;
	typedef logic [ACC_W-1:0]   acc_t;
	typedef logic [VALUE_W-1:0] value_t;
	typedef logic [LEN_W-1:0]   len_t;
	typedef logic [CNT_W-1:0]   cnt_t;

	// Register index, taken from the word address.
	typedef enum logic {
		REG_SIGNED_MODE = 1'b0,
		REG_UNUSED      = 1'b1
	} reg_idx_t;

	localparam byte_t MARKER_TOP = 8'h80;

	// Length from the first byte: one plus the count of leading zeros.
	function automatic len_t first_len(input byte_t b);
		len_t len;
		len = len_t'(BYTE_W);
		for (int i = 0; i < BYTE_W; i++) begin
			if (b[i]) begin
				len = len_t'(BYTE_W - i);
			end
		end
		return len;
	endfunction

	// Signed-mode bias 2^(7*len-1)-1.
	function automatic value_t bias(input len_t len);
		value_t b;
		unique case (len)
			4'd1:    b = 57'h3F;
			4'd2:    b = 57'h1FFF;
			4'd3:    b = 57'hFFFFF;
			4'd4:    b = 57'h7FFFFFF;
			4'd5:    b = 57'h3FFFFFFFF;
			4'd6:    b = 57'h1FFFFFFFFFF;
			4'd7:    b = 57'hFFFFFFFFFFFF;
			4'd8:    b = 57'h7FFFFFFFFFFFFF;
			default: b = '0;
		endcase
		return b;
	endfunction

endpackage

// ===== sv/ebml_vint_decoder_core.sv =====
// EBML variable-size integer decoder: byte stream in, decoded value and length out.
// An accepted byte is registered in the input stage; its result, when it closes an integer,
// is then registered in the output register.
// Throughput: one byte per cycle; the input stage stalls only while it holds a closing
// byte and the output register still holds an untaken result.
// Reset (arst_n low, asynchronous): pipeline empty, decoder waiting for a first byte,
// accumulator and length cleared, signed_mode cleared to unsigned decode.
`include "ebml_vint_decoder_core_defines.svh"

module ebml_vint_decoder_core (
	input  logic                                   clk,
	input  logic                                   arst_n,
	// Byte stream
	input  logic                                   in_valid,
	output logic                                   in_ready,
	input  logic [ebmlvd_pkg::BYTE_W-1:0]          data_byte,
	// Results
	output logic                                   out_valid,
	input  logic                                   out_ready,
	output logic signed [ebmlvd_pkg::VALUE_W-1:0]  value,
	output logic [ebmlvd_pkg::LEN_W-1:0]           byte_length,
	output logic                                   invalid,
	// Configuration
	input  logic                                   psel,
	input  logic                                   penable,
	input  logic                                   pwrite,
	input  logic [ebmlvd_pkg::PADDR_W-1:0]         paddr,
	input  logic [ebmlvd_pkg::PDATA_W-1:0]         pwdata,
	output logic [ebmlvd_pkg::PDATA_W-1:0]         prdata,
	output logic                                   pready
);

	// ------------------------------------------------------------------
	// Configuration register. Word address selects the register; only
	// signed_mode exists, other words read as zero and ignore writes.
	// ------------------------------------------------------------------
	logic                 signed_mode_q;
	ebmlvd_pkg::reg_idx_t reg_idx;

	assign pready  = 1'b1;
	assign reg_idx = ebmlvd_pkg::reg_idx_t'(paddr[ebmlvd_pkg::PADDR_W-1]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			signed_mode_q <= 1'b0;
		end else if (psel && penable && pwrite && pready
				&& reg_idx == ebmlvd_pkg::REG_SIGNED_MODE) begin
			signed_mode_q <= pwdata[0];
		end
	end

	always_comb begin
		prdata = '0;
		unique case (reg_idx)
			ebmlvd_pkg::REG_SIGNED_MODE: prdata[0] = signed_mode_q;
			default:                     prdata    = '0;
		endcase
	end

	// ------------------------------------------------------------------
	// Input stage: hold the accepted byte until the decode step retires it.
	// ------------------------------------------------------------------
	logic                  valid_s1;
	ebmlvd_pkg::byte_t     data_s1;
	logic                  s1_fire;
	logic                  out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			data_s1 <= data_byte;
		end
	end

	// Decoder state: continuation bytes still due, value so far, length.
	ebmlvd_pkg::cnt_t bytes_left_q;
	ebmlvd_pkg::acc_t acc_q;
	ebmlvd_pkg::len_t cur_len_q;

	ebmlvd_pkg::cnt_t   bytes_left_d;
	ebmlvd_pkg::acc_t   acc_d;
	ebmlvd_pkg::len_t   cur_len_d;
	ebmlvd_pkg::len_t   lead_len;
	ebmlvd_pkg::byte_t  marker;
	logic               emit;
	logic               bad_first;
	ebmlvd_pkg::value_t bias_sel;
	ebmlvd_pkg::value_t result_val;

	// Decode step. A first byte sets the length from its leading zeros and
	// drops the marker bit; a continuation byte shifts in big-endian.
	always_comb begin
		lead_len     = ebmlvd_pkg::first_len(data_s1);
		marker       = ebmlvd_pkg::MARKER_TOP >> ebmlvd_pkg::cnt_t'(lead_len - 4'd1);
		bad_first    = 1'b0;
		bytes_left_d = bytes_left_q;
		acc_d        = acc_q;
		cur_len_d    = cur_len_q;
		if (bytes_left_q == '0) begin
			if (data_s1 == '0) begin
				// Zero first byte: length would exceed eight; report and stay idle.
				bad_first    = 1'b1;
				acc_d        = '0;
				cur_len_d    = '0;
				bytes_left_d = '0;
			end else begin
				cur_len_d    = lead_len;
				acc_d        = ebmlvd_pkg::acc_t'(data_s1 & ~marker);
				bytes_left_d = ebmlvd_pkg::cnt_t'(lead_len - 4'd1);
			end
		end else begin
			acc_d        = {acc_q[ebmlvd_pkg::ACC_W-ebmlvd_pkg::BYTE_W-1:0], data_s1};
			bytes_left_d = bytes_left_q - 3'd1;
		end
		emit = bad_first || (bytes_left_d == '0);
	end

	// Result value: subtract the bias in signed mode (one 57-bit subtract).
	always_comb begin
		bias_sel   = signed_mode_q ? ebmlvd_pkg::bias(cur_len_d) : '0;
		result_val = bad_first ? '0 : ({1'b0, acc_d} - bias_sel);
	end

	// Advance the input stage when the byte closes nothing, or the output
	// register can take the result this cycle.
	assign out_free = !out_valid || out_ready;
	assign s1_fire  = valid_s1 && (!emit || out_free);
	assign in_ready = !valid_s1 || s1_fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bytes_left_q <= '0;
			acc_q        <= '0;
			cur_len_q    <= '0;
		end else if (s1_fire) begin
			bytes_left_q <= bytes_left_d;
			acc_q        <= acc_d;
			cur_len_q    <= cur_len_d;
		end
	end

	// ------------------------------------------------------------------
	// Output register: hold the result until the consumer takes it.
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (s1_fire && emit) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_fire && emit) begin
			value       <= result_val;
			byte_length <= cur_len_d;
			invalid     <= bad_first;
		end
	end

	// ------------------------------------------------------------------
	// Checks
	// ------------------------------------------------------------------
	`EVD_ASSERT_IMP(a_left_below_len, bytes_left_q != '0,
		{1'b0, bytes_left_q} < cur_len_q)
	`EVD_ASSERT_IMP(a_invalid_zero, out_valid && invalid,
		byte_length == '0 && value == '0)
	`EVD_ASSERT_IMP(a_len_range, out_valid && !invalid,
		byte_length >= 4'd1 && byte_length <= 4'd8)
	`EVD_ASSERT_NXT(a_s1_hold, valid_s1 && !s1_fire,
		valid_s1 && $stable(data_s1))

endmodule
